// ----- hdl/hscb_pkg.sv -----
// Package for the heap size-class bitmap: widths, operation and status codes,
// and the result type passed from the size classifier to the top level.
// Depends on nothing; every other file uses it by scoped names.
package hscb_pkg;

	localparam int NUM_CLASSES = 128;
	localparam int SIZE_BITS   = 20;

	localparam int OP_W     = 2;
	localparam int BUCKET_W = 7;
	localparam int STATUS_W = 2;
	localparam int CLS_W    = 7;
	localparam int RSIZE_W  = 21;

	localparam int CIDX_W = $clog2(NUM_CLASSES);
	localparam int SW1    = SIZE_BITS + 1;
	localparam int TB_W   = $clog2(SW1 + 1);
	localparam int CODE_W = $clog2(8 * SIZE_BITS + 2 * NUM_CLASSES);

	localparam int ALIGN_BYTES  = 8;
	localparam int LINEAR_LIMIT = 16 * ALIGN_BYTES;
	localparam int MIN_FREE     = 16;
	localparam int CODE_BIAS    = 17;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP   = 2'd0,
		OP_FREE     = 2'd1,
		OP_EMPTY    = 2'd2,
		OP_CLASSIFY = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_NONE = 2'd1,
		STAT_BIG  = 2'd2,
		STAT_ZERO = 2'd3
	} status_t;

	typedef struct packed {
		logic              in_range;
		logic [CIDX_W-1:0] idx;
		logic [SW1-1:0]    rounded;
	} cls_res_t;

	typedef struct packed {
		logic              set;
		logic              clr;
		logic [CIDX_W-1:0] idx;
	} bm_upd_t;

endpackage

// ----- hdl/heap_size_class_bitmap.sv -----
// Top level of the heap size-class bitmap: input register, operation decode,
// result register. Depends on hscb_pkg, hscb_classify and hscb_bitmap.
//
// Channel   Ports                                         Transaction
// command   start, busy, op, size, bucket                 start high, busy low
// result    done, status, class_index, found_class,       done high, one cycle
//           rounded_size
//
// A command is registered at the edge that accepts it, and its result is
// registered on the result ports at the edge after that.
// busy stays low: a command can be accepted at every edge.
// The bitmap is updated at the same edge that registers the result, so a
// command sees the effect of the one accepted just before it.
// Reset clears the bitmap (every class empty) and the valid flags.
module heap_size_class_bitmap (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [hscb_pkg::OP_W-1:0]        op,
	input  logic [hscb_pkg::SIZE_BITS-1:0]   size,
	input  logic [hscb_pkg::BUCKET_W-1:0]    bucket,
	output logic                             done,
	output logic [hscb_pkg::STATUS_W-1:0]    status,
	output logic [hscb_pkg::CLS_W-1:0]       class_index,
	output logic [hscb_pkg::CLS_W-1:0]       found_class,
	output logic [hscb_pkg::RSIZE_W-1:0]     rounded_size
);

	localparam int CIDX_W = hscb_pkg::CIDX_W;

	logic                             valid_s1;
	hscb_pkg::op_t                    op_s1;
	logic [hscb_pkg::SIZE_BITS-1:0]   size_s1;
	logic [hscb_pkg::BUCKET_W-1:0]    bucket_s1;

	hscb_pkg::cls_res_t               cres;
	hscb_pkg::bm_upd_t                upd;
	logic                             found;
	logic [CIDX_W-1:0]                found_idx;

	hscb_pkg::status_t                status_d;
	logic [hscb_pkg::CLS_W-1:0]       class_d;
	logic [hscb_pkg::CLS_W-1:0]       found_d;
	logic [hscb_pkg::RSIZE_W-1:0]     rsize_d;
	logic                             size_zero;
	logic                             bucket_ok;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1     <= hscb_pkg::op_t'(op);
			size_s1   <= size;
			bucket_s1 <= bucket;
		end
	end

	hscb_classify u_classify (
		.size (size_s1),
		.up   (op_s1 == hscb_pkg::OP_LOOKUP),
		.res  (cres)
	);

	hscb_bitmap u_bitmap (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.start_idx (cres.idx),
		.found     (found),
		.found_idx (found_idx)
	);

	assign size_zero = (size_s1 == '0) || ((op_s1 != hscb_pkg::OP_LOOKUP) &&
		(size_s1 < hscb_pkg::SIZE_BITS'(hscb_pkg::ALIGN_BYTES)));
	assign bucket_ok = 32'(bucket_s1) < hscb_pkg::NUM_CLASSES;

	always_comb begin
		status_d = hscb_pkg::STAT_OK;
		class_d  = '0;
		found_d  = '0;
		rsize_d  = '0;
		upd.set  = 1'b0;
		upd.clr  = 1'b0;
		upd.idx  = cres.idx;
		if (op_s1 == hscb_pkg::OP_EMPTY) begin
			class_d = hscb_pkg::CLS_W'(bucket_s1);
			upd.idx = CIDX_W'(bucket_s1);
			if (bucket_ok) begin
				upd.clr = valid_s1;
			end else begin
				status_d = hscb_pkg::STAT_BIG;
			end
		end else if (size_zero) begin
			status_d = hscb_pkg::STAT_ZERO;
		end else if (!cres.in_range) begin
			status_d = hscb_pkg::STAT_BIG;
		end else if (op_s1 == hscb_pkg::OP_LOOKUP) begin
			class_d = hscb_pkg::CLS_W'(cres.idx);
			rsize_d = hscb_pkg::RSIZE_W'(cres.rounded);
			if (found) begin
				found_d = hscb_pkg::CLS_W'(found_idx);
			end else begin
				status_d = hscb_pkg::STAT_NONE;
			end
		end else begin
			class_d = hscb_pkg::CLS_W'(cres.idx);
			upd.set = valid_s1 && (op_s1 == hscb_pkg::OP_FREE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status       <= status_d;
		class_index  <= class_d;
		found_class  <= found_d;
		rounded_size <= rsize_d;
	end

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("Result strobe missing after a registered command.");

	a_found_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hscb_pkg::STAT_OK && rounded_size != '0) |->
		(found_class >= class_index))
		else $error("Found class lies below the start class.");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hscb_pkg::STAT_ZERO) |->
		(class_index == '0 && found_class == '0 && rounded_size == '0))
		else $error("Zero-size result carries nonzero fields.");

	a_none_rounded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hscb_pkg::STAT_NONE) |->
		(rounded_size != '0 && found_class == '0))
		else $error("None-found result has inconsistent fields.");
`endif

endmodule

// ----- hdl/hscb_classify.sv -----
// Size classifier: maps a payload size to its size class, rounding up or down,
// and gives the rounded-up class size when rounding up. Purely combinational.
// Depends on hscb_pkg.
module hscb_classify (
	input  logic [hscb_pkg::SIZE_BITS-1:0] size,
	input  logic                           up,
	output hscb_pkg::cls_res_t             res
);

	localparam int SW1    = hscb_pkg::SW1;
	localparam int TB_W   = hscb_pkg::TB_W;
	localparam int CODE_W = hscb_pkg::CODE_W;

	logic [SW1-1:0]    s_up;
	logic [SW1-1:0]    s_sel;
	logic [SW1-1:0]    s_adj;
	logic              linear;
	logic [TB_W-1:0]   top;
	logic [TB_W-1:0]   grp;
	logic [SW1-1:0]    shifted;
	logic [2:0]        mant;
	logic [CODE_W-1:0] code;
	logic [CODE_W-1:0] lin_class;
	logic [CODE_W-1:0] class_full;
	logic [SW1-1:0]    base;
	logic [SW1-1:0]    geo_round;
	logic [SW1-1:0]    lin_round;

	assign s_up   = (SW1'(size) + SW1'(hscb_pkg::ALIGN_BYTES - 1)) &
		~SW1'(hscb_pkg::ALIGN_BYTES - 1);
	assign s_sel  = up ? s_up : SW1'(size);
	assign linear = s_sel <= SW1'(hscb_pkg::LINEAR_LIMIT);
	assign s_adj  = up ? s_sel - SW1'(hscb_pkg::ALIGN_BYTES) : s_sel;

	always_comb begin
		top = '0;
		for (int i = 0; i < SW1; i++) begin
			if (s_adj[i]) begin
				top = TB_W'(i);
			end
		end
	end

	assign grp     = top - TB_W'(3);
	assign shifted = s_adj >> grp;
	assign mant    = shifted[2:0];
	assign code    = CODE_W'({grp, mant}) + CODE_W'(up);

	assign lin_class  = CODE_W'(s_sel >> 3) - CODE_W'(1);
	assign class_full = linear ? lin_class : code - CODE_W'(hscb_pkg::CODE_BIAS);

	assign base      = SW1'(code[2:0]) + SW1'(8);
	assign geo_round = base << code[CODE_W-1:3];
	assign lin_round = (s_sel < SW1'(hscb_pkg::MIN_FREE)) ?
		SW1'(hscb_pkg::MIN_FREE) : s_sel;

	assign res.in_range = class_full < CODE_W'(hscb_pkg::NUM_CLASSES);
	assign res.idx      = hscb_pkg::CIDX_W'(class_full);
	assign res.rounded  = linear ? lin_round : geo_round;

endmodule

// ----- hdl/hscb_bitmap.sv -----
// Nonempty bitmap with one bit per size class, its set and clear port, and
// the masked priority search for the lowest set bit at or above a start class.
// Depends on hscb_pkg.
module hscb_bitmap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hscb_pkg::bm_upd_t                   upd,
	input  logic [hscb_pkg::CIDX_W-1:0]         start_idx,
	output logic                                found,
	output logic [hscb_pkg::CIDX_W-1:0]         found_idx
);

	localparam int NC = hscb_pkg::NUM_CLASSES;

	logic [NC-1:0] bits_q;
	logic [NC-1:0] masked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (upd.set) begin
			bits_q[upd.idx] <= 1'b1;
		end else if (upd.clr) begin
			bits_q[upd.idx] <= 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			masked[i] = bits_q[i] && (i >= int'(start_idx));
		end
	end

	always_comb begin
		found_idx = '0;
		for (int i = NC - 1; i >= 0; i--) begin
			if (masked[i]) begin
				found_idx = hscb_pkg::CIDX_W'(i);
			end
		end
	end

	assign found = |masked;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for heap_size_class_bitmap: directed and random commands
// against an in-bench model of the size classes and the nonempty bitmap.
// Depends on hscb_pkg and the heap_size_class_bitmap RTL.
`timescale 1ns / 100ps

module tb;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		hscb_pkg::status_t                status;
		logic [hscb_pkg::CLS_W-1:0]       cls;
		logic [hscb_pkg::CLS_W-1:0]       found;
		logic [hscb_pkg::RSIZE_W-1:0]     rsize;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [hscb_pkg::OP_W-1:0] op = hscb_pkg::OP_LOOKUP;
	logic [hscb_pkg::SIZE_BITS-1:0] size = '0;
	logic [hscb_pkg::BUCKET_W-1:0] bucket = '0;
	logic done;
	logic [hscb_pkg::STATUS_W-1:0] status;
	logic [hscb_pkg::CLS_W-1:0] class_index;
	logic [hscb_pkg::CLS_W-1:0] found_class;
	logic [hscb_pkg::RSIZE_W-1:0] rounded_size;

	logic [hscb_pkg::NUM_CLASSES-1:0] free_map = '0;
	answer_t answer_q[$];
	int mismatch_count = 0;
	int stall_cycles = 0;
	bit idle_en = 1'b1;

	heap_size_class_bitmap u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.size(size),
		.bucket(bucket),
		.done(done),
		.status(status),
		.class_index(class_index),
		.found_class(found_class),
		.rounded_size(rounded_size)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Round-up for lookups, round-down for free and classify.
	function automatic longint unsigned class_for_size(input longint unsigned s_in,
			input bit round_up, output longint unsigned rnd);
		longint unsigned s;
		longint unsigned grp;
		longint unsigned code;
		int top;
		s = s_in;
		top = 0;
		if (round_up)
			s = (s + hscb_pkg::ALIGN_BYTES - 1) & ~longint'(hscb_pkg::ALIGN_BYTES - 1);
		if (s <= hscb_pkg::LINEAR_LIMIT) begin
			rnd = (s < hscb_pkg::MIN_FREE) ? hscb_pkg::MIN_FREE : s;
			return s / hscb_pkg::ALIGN_BYTES - 1;
		end
		if (round_up)
			s = s - hscb_pkg::ALIGN_BYTES;
		for (int p = 0; p < 64; p++)
			if (s[p])
				top = p;
		grp = top - 3;
		code = (grp << 3) | ((s >> grp) & 7);
		if (round_up)
			code++;
		rnd = (longint'(8) + (code & 7)) << (code >> 3);
		return code - hscb_pkg::CODE_BIAS;
	endfunction

	function automatic answer_t bitmap_answer(input hscb_pkg::op_t o,
			input logic [hscb_pkg::SIZE_BITS-1:0] s,
			input logic [hscb_pkg::BUCKET_W-1:0] b);
		answer_t a;
		longint unsigned idx;
		longint unsigned rnd;
		int k;
		a = '{hscb_pkg::STAT_OK, '0, '0, '0};
		if (o == hscb_pkg::OP_EMPTY) begin
			a.cls = b;
			if (b < hscb_pkg::NUM_CLASSES)
				free_map[b] = 1'b0;
			else
				a.status = hscb_pkg::STAT_BIG;
		end else if (s == 0 || (o != hscb_pkg::OP_LOOKUP && s < hscb_pkg::ALIGN_BYTES)) begin
			a.status = hscb_pkg::STAT_ZERO;
		end else begin
			idx = class_for_size(s, o == hscb_pkg::OP_LOOKUP, rnd);
			if (idx >= hscb_pkg::NUM_CLASSES) begin
				a.status = hscb_pkg::STAT_BIG;
			end else if (o == hscb_pkg::OP_LOOKUP) begin
				a.cls = idx[hscb_pkg::CLS_W-1:0];
				a.rsize = rnd[hscb_pkg::RSIZE_W-1:0];
				k = int'(idx);
				while (k < hscb_pkg::NUM_CLASSES && !free_map[k])
					k++;
				if (k < hscb_pkg::NUM_CLASSES)
					a.found = k[hscb_pkg::CLS_W-1:0];
				else
					a.status = hscb_pkg::STAT_NONE;
			end else begin
				a.cls = idx[hscb_pkg::CLS_W-1:0];
				if (o == hscb_pkg::OP_FREE)
					free_map[idx] = 1'b1;
			end
		end
		return a;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_command(input hscb_pkg::op_t o,
			input logic [hscb_pkg::SIZE_BITS-1:0] s,
			input logic [hscb_pkg::BUCKET_W-1:0] b);
		if (idle_en) begin
			while ($urandom_range(0, 99) < 27) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		op <= o;
		size <= s;
		bucket <= b;
		do @(posedge clk); while (busy);
		answer_q.push_back(bitmap_answer(o, s, b));
	endtask

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				flag_mismatch("unexpected transaction, status", status, 0);
			end else begin
				want = answer_q.pop_front();
				if (status !== want.status)
					flag_mismatch("status", status, want.status);
				if (class_index !== want.cls)
					flag_mismatch("class_index", class_index, want.cls);
				if (found_class !== want.found)
					flag_mismatch("found_class", found_class, want.found);
				if (rounded_size !== want.rsize)
					flag_mismatch("rounded_size", rounded_size, want.rsize);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("heap_size_class_bitmap regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [hscb_pkg::SIZE_BITS-1:0] random_size();
		int mag;
		int g;
		logic [hscb_pkg::SIZE_BITS-1:0] s;
		if ($urandom_range(0, 9) == 0) begin
			g = $urandom_range(4, hscb_pkg::SIZE_BITS - 4);
			s = hscb_pkg::SIZE_BITS'(((8 + $urandom_range(0, 7)) << g) +
				$urandom_range(0, 2) - 1);
		end else begin
			mag = $urandom_range(0, hscb_pkg::SIZE_BITS);
			s = hscb_pkg::SIZE_BITS'($urandom & ((longint'(1) << mag) - 1));
		end
		return s;
	endfunction

	function automatic logic [hscb_pkg::BUCKET_W-1:0] random_bucket();
		int k;
		k = $urandom_range(0, hscb_pkg::NUM_CLASSES - 1);
		if ($urandom_range(0, 9) < 6)
			for (int n = 0; n < hscb_pkg::NUM_CLASSES; n++)
				if (free_map[(k + n) % hscb_pkg::NUM_CLASSES])
					return hscb_pkg::BUCKET_W'((k + n) % hscb_pkg::NUM_CLASSES);
		return hscb_pkg::BUCKET_W'(k);
	endfunction

	task automatic random_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			send_command(hscb_pkg::OP_LOOKUP, random_size(), hscb_pkg::BUCKET_W'($urandom));
		else if (r < 65)
			send_command(hscb_pkg::OP_FREE, random_size(), hscb_pkg::BUCKET_W'($urandom));
		else if (r < 85)
			send_command(hscb_pkg::OP_EMPTY, hscb_pkg::SIZE_BITS'($urandom), random_bucket());
		else
			send_command(hscb_pkg::OP_CLASSIFY, random_size(),
				hscb_pkg::BUCKET_W'($urandom));
	endtask

	task automatic test_lookup_empty_map();
		send_command(hscb_pkg::OP_LOOKUP, 1, 0);
		send_command(hscb_pkg::OP_LOOKUP, 8, '1);
		send_command(hscb_pkg::OP_LOOKUP, 9, 0);
		send_command(hscb_pkg::OP_LOOKUP, 128, 0);
		send_command(hscb_pkg::OP_LOOKUP, 129, 0);
		send_command(hscb_pkg::OP_LOOKUP, '1, 0);
	endtask

	task automatic test_zero_and_tiny();
		send_command(hscb_pkg::OP_LOOKUP, 0, 0);
		send_command(hscb_pkg::OP_FREE, 0, 0);
		send_command(hscb_pkg::OP_FREE, 7, 0);
		send_command(hscb_pkg::OP_CLASSIFY, 7, 0);
	endtask

	task automatic test_classify_edges();
		send_command(hscb_pkg::OP_CLASSIFY, 8, 0);
		send_command(hscb_pkg::OP_CLASSIFY, 15, 0);
		send_command(hscb_pkg::OP_CLASSIFY, 128, 0);
		send_command(hscb_pkg::OP_CLASSIFY, 143, 0);
		send_command(hscb_pkg::OP_CLASSIFY, 144, 0);
		send_command(hscb_pkg::OP_CLASSIFY, '1, 0);
	endtask

	task automatic test_free_then_lookup();
		send_command(hscb_pkg::OP_FREE, '1, 0);
		send_command(hscb_pkg::OP_FREE, 16, 0);
		send_command(hscb_pkg::OP_FREE, 300, 0);
		send_command(hscb_pkg::OP_LOOKUP, 17, 0);
		send_command(hscb_pkg::OP_LOOKUP, 200, 0);
		send_command(hscb_pkg::OP_LOOKUP, '1, 0);
		send_command(hscb_pkg::OP_EMPTY, 0, 0);
		send_command(hscb_pkg::OP_EMPTY, '1, hscb_pkg::BUCKET_W'(hscb_pkg::NUM_CLASSES - 1));
		send_command(hscb_pkg::OP_LOOKUP, 9, 0);
	endtask

	task automatic test_random_mix(input int count);
		idle_en = 1'b1;
		repeat (count) random_command();
	endtask

	task automatic test_back_to_back(input int count);
		idle_en = 1'b0;
		repeat (count) random_command();
		idle_en = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lookup_empty_map();
		test_zero_and_tiny();
		test_classify_edges();
		test_free_then_lookup();
		test_random_mix(400);
		test_back_to_back(300);
		test_random_mix(300);
		start <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("heap_size_class_bitmap regression: pass");
		else
			$display("heap_size_class_bitmap regression: fail");
		$finish;
	end

endmodule
